>>> design/hda_pkg.sv
package hda_pkg;

    localparam int unsigned F32_W = 32;
    localparam int unsigned F16_W = 16;

    localparam logic [31:0] F32_SIGN        = 32'h8000_0000;
    localparam logic [30:0] F32_INF_MAG     = 31'h7F80_0000;
    localparam logic [31:0] F32_QBIT        = 32'h0040_0000;
    localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [7:0]  F32_EXP_MAX     = 8'hFF;

    // half to single exponent rebias
    localparam logic [7:0]  EXP_REBIAS      = 8'd112;

    // working mantissa: hidden bit, 23 fraction bits, guard, round, sticky
    localparam int unsigned WM_W            = 27;

    typedef logic [F32_W-1:0] t_f32;
    typedef logic [F16_W-1:0] t_f16;

endpackage

>>> design/half_decode_accumulate_top.sv
// Data path: an accepted transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle while i_out_stall is low; the input and result registers
// form a two-stage pipeline around the combinational widen-and-add path.
// Reset: synchronous, active low; clears both valid flags, payload is not reset.
module half_decode_accumulate_top
    import hda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_acc_value,
    input  logic [15:0] i_half_value,
    input  logic        i_last_element,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_sum_value,
    output logic        o_last_out
);

    // input register
    logic r_a_valid;
    t_f32 r_acc;
    t_f16 r_half;
    logic r_last;

    // result register
    logic r_o_valid;
    t_f32 r_sum;
    logic r_o_last;

    logic n_o_move;   // result register can take a new value
    logic n_a_move;   // input register can take a new value
    t_f32 widened;
    t_f32 sum;

    assign n_o_move   = !r_o_valid || !i_out_stall;
    assign n_a_move   = !r_a_valid || n_o_move;
    assign o_in_stall = !n_a_move;

    hda_widen u_widen (
        .i_half   (r_half),
        .o_single (widened)
    );

    // single pass: NaN/inf screen, align, add, normalise, round to nearest even
    hda_add u_add (
        .i_a   (r_acc),
        .i_b   (widened),
        .o_sum (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (n_a_move) begin
                r_a_valid <= i_in_valid;
            end
            if (n_o_move) begin
                r_o_valid <= r_a_valid;
            end
        end
        if (n_a_move && i_in_valid) begin
            r_acc  <= i_acc_value;
            r_half <= i_half_value;
            r_last <= i_last_element;
        end
        if (n_o_move && r_a_valid) begin
            r_sum    <= sum;
            r_o_last <= r_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_sum_value = r_sum;
    assign o_last_out  = r_o_last;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_valid && r_o_valid && i_out_stall))
        else $error("input stalled without a full pipeline");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && n_o_move) |=> r_o_valid)
        else $error("transaction lost between stages");
`endif

endmodule

>>> design/hda_widen.sv
module hda_widen
    import hda_pkg::*;
(
    input  t_f16 i_half,
    output t_f32 o_single
);

    logic       sign;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] top;
    logic [9:0] sub_frac;
    logic [7:0] sub_exp;

    assign sign = i_half[15];
    assign e    = i_half[14:10];
    assign m    = i_half[9:0];

    // position of the leading one of a subnormal fraction
    always_comb begin
        top = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                top = 4'(i);
            end
        end
    end

    assign sub_frac = 10'(m << (4'd10 - top));
    assign sub_exp  = 8'd103 + {4'd0, top};

    always_comb begin
        if (e == 5'h1F) begin
            o_single = {sign, F32_EXP_MAX, m, 13'd0};
        end else if (e != 5'd0) begin
            o_single = {sign, {3'd0, e} + EXP_REBIAS, m, 13'd0};
        end else if (m == 10'd0) begin
            o_single = {sign, 31'd0};
        end else begin
            o_single = {sign, sub_exp, sub_frac, 13'd0};
        end
    end

endmodule

>>> design/hda_add.sv
module hda_add
    import hda_pkg::*;
(
    input  t_f32 i_a,
    input  t_f32 i_b,
    output t_f32 o_sum
);

    logic              nan_a, nan_b, inf_a, inf_b, swap;
    t_f32              big, lit;
    logic              sa, sb;
    logic [7:0]        ea, eb, d;
    logic [WM_W-1:0]   ma, mb, mb_al, mask;
    logic [WM_W:0]     m_raw;
    logic [WM_W-1:0]   m_pre, m_norm;
    logic [8:0]        e_pre, e_norm, e_fin;
    logic [4:0]        lz, sh;
    logic [24:0]       mr;
    logic              rnd_up;
    t_f32              arith;
    logic              zero_diff, zero_sum;

    assign nan_a = i_a[30:0] > F32_INF_MAG;
    assign nan_b = i_b[30:0] > F32_INF_MAG;
    assign inf_a = i_a[30:0] == F32_INF_MAG;
    assign inf_b = i_b[30:0] == F32_INF_MAG;

    assign swap = i_b[30:0] > i_a[30:0];
    assign big  = swap ? i_b : i_a;
    assign lit  = swap ? i_a : i_b;
    assign sa   = big[31];
    assign sb   = lit[31];
    assign ea   = (big[30:23] != 8'd0) ? big[30:23] : 8'd1;
    assign eb   = (lit[30:23] != 8'd0) ? lit[30:23] : 8'd1;
    assign ma   = {big[30:23] != 8'd0, big[22:0], 3'b000};
    assign mb   = {lit[30:23] != 8'd0, lit[22:0], 3'b000};
    assign d    = ea - eb;

    // alignment with sticky
    always_comb begin
        mask = ~({WM_W{1'b1}} << d[4:0]);
        if (d >= 8'(WM_W)) begin
            mb_al = {{(WM_W-1){1'b0}}, mb != '0};
        end else begin
            mb_al = (mb >> d[4:0]) | {{(WM_W-1){1'b0}}, (mb & mask) != '0};
        end
    end

    always_comb begin
        e_pre = {1'b0, ea};
        if (sa == sb) begin
            m_raw = {1'b0, ma} + {1'b0, mb_al};
        end else begin
            m_raw = {1'b0, ma} - {1'b0, mb_al};
        end
        if (m_raw[WM_W]) begin
            m_pre = m_raw[WM_W:1] | {{(WM_W-1){1'b0}}, m_raw[0]};
            e_pre = e_pre + 9'd1;
        end else begin
            m_pre = m_raw[WM_W-1:0];
        end
    end

    assign zero_diff = (sa != sb) && (m_raw == '0);
    assign zero_sum  = (sa == sb) && (m_raw == '0);

    // leading zero count, limited so the exponent stays at one or above
    always_comb begin
        lz = 5'd27;
        for (int i = 0; i < WM_W; i++) begin
            if (m_pre[i]) begin
                lz = 5'(WM_W - 1 - i);
            end
        end
        sh = ({4'd0, lz} < e_pre - 9'd1) ? lz : 5'(e_pre - 9'd1);
    end

    assign m_norm = m_pre << sh;
    assign e_norm = e_pre - {4'd0, sh};

    assign rnd_up = (m_norm[2:0] > 3'd4) || (m_norm[2:0] == 3'd4 && m_norm[3]);

    always_comb begin
        mr    = {1'b0, m_norm[WM_W-1:3]} + {24'd0, rnd_up};
        e_fin = e_norm;
        if (mr[24]) begin
            mr    = mr >> 1;
            e_fin = e_fin + 9'd1;
        end
        if (e_fin >= 9'd255) begin
            arith = {sa, F32_INF_MAG};
        end else if (!mr[23]) begin
            arith = {sa, 8'd0, mr[22:0]};
        end else begin
            arith = {sa, e_fin[7:0], mr[22:0]};
        end
    end

    always_comb begin
        if (nan_a) begin
            o_sum = i_a | F32_QBIT;
        end else if (nan_b) begin
            o_sum = i_b | F32_QBIT;
        end else if (inf_a) begin
            o_sum = (inf_b && (i_a[31] != i_b[31])) ? F32_DEFAULT_NAN : i_a;
        end else if (inf_b) begin
            o_sum = i_b;
        end else if (zero_diff) begin
            o_sum = '0;
        end else if (zero_sum) begin
            o_sum = {sa, 31'd0};
        end else begin
            o_sum = arith;
        end
    end

endmodule
